@@ rtl/core/multi_slot_software_watchdog_unit_defines.svh @@
// Assertion macros shared by the watchdog checker.
`ifndef MULTI_SLOT_SOFTWARE_WATCHDOG_UNIT_DEFINES_SVH
`define MULTI_SLOT_SOFTWARE_WATCHDOG_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MSWD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MSWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mswd_pkg.sv @@
// Package: opcodes, status codes, packet type and defaults of the watchdog table.
`default_nettype none
package mswd_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int CFG_AW    = 3;
  localparam logic [7:0] STEP_RESET = 8'd10;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [4:0]  EXP_MAX   = 5'd31;

  // register index taken from paddr[2]
  localparam logic REG_COUNT_STEP = 1'b0;

  typedef enum logic [2:0] {
    OP_JOIN  = 3'd0,
    OP_SETTO = 3'd1,
    OP_LEAVE = 3'd2,
    OP_CLEAR = 3'd3,
    OP_TICK  = 3'd4,
    OP_READ  = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_UNUSED = 2'd2;

  // word walking down the cell chain
  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [3:0]  sel;
    logic [15:0] tmo;
    logic        found;
    logic [3:0]  slot;
    logic        hit;
    logic [4:0]  expired;
    logic        used;
    logic [15:0] cnt;
    logic [15:0] peak;
    logic [15:0] lim;
  } pkt_t;

endpackage
`default_nettype wire

@@ rtl/core/mswd_if.sv @@
// Valid/ready channel interfaces for command words and result words.
`default_nettype none
interface mswd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  slot_sel;
  logic [15:0] timeout_value;

  modport source (output valid, opcode, slot_sel, timeout_value, input ready);
  modport sink   (input valid, opcode, slot_sel, timeout_value, output ready);
endinterface

interface mswd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  slot_out;
  logic [4:0]  expired_count;
  logic        kick;
  logic        slot_used;
  logic [15:0] slot_count;
  logic [15:0] slot_peak;
  logic [15:0] slot_timeout;

  modport source (output valid, status, slot_out, expired_count, kick, slot_used,
                  slot_count, slot_peak, slot_timeout, input ready);
  modport sink   (input valid, status, slot_out, expired_count, kick, slot_used,
                  slot_count, slot_peak, slot_timeout, output ready);
endinterface
`default_nettype wire

@@ rtl/core/mswd_cell.sv @@
// One watchdog slot: holds its state and acts on the word passing through it.
`default_nettype none
module mswd_cell
  import mswd_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire logic [7:0] step,
  input  wire pkt_t       pkt_i,
  output pkt_t            pkt_o
);

  localparam logic [7:0] MY_IDX = 8'(IDX);

  logic        used_r, used_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] peak_r, peak_nxt;
  logic [15:0] lim_r, lim_nxt;
  pkt_t        pkt_r, pkt_nxt;

  logic        sel_me;
  logic [16:0] sum;
  logic [15:0] cnt_sat;

  assign sel_me  = ({4'b0, pkt_i.sel} == MY_IDX);
  assign sum     = {1'b0, cnt_r} + {9'b0, step};
  assign cnt_sat = sum[16] ? COUNT_MAX : sum[15:0];

  always_comb begin
    used_nxt = used_r;
    cnt_nxt  = cnt_r;
    peak_nxt = peak_r;
    lim_nxt  = lim_r;
    pkt_nxt  = pkt_i;
    if (pkt_i.valid) begin
      case (pkt_i.op)
        OP_JOIN: begin
          // first free cell on the path claims the join
          if (!pkt_i.found && !used_r) begin
            used_nxt      = 1'b1;
            cnt_nxt       = '0;
            peak_nxt      = '0;
            lim_nxt       = pkt_i.tmo;
            pkt_nxt.found = 1'b1;
            pkt_nxt.slot  = MY_IDX[3:0];
          end
        end
        OP_SETTO, OP_LEAVE, OP_CLEAR: begin
          if (sel_me && used_r) begin
            pkt_nxt.hit = 1'b1;
            if (pkt_i.op == OP_SETTO) lim_nxt = pkt_i.tmo;
            else if (pkt_i.op == OP_LEAVE) used_nxt = 1'b0;
            else cnt_nxt = '0;
          end
        end
        OP_TICK: begin
          if (used_r) begin
            cnt_nxt = cnt_sat;
            if (cnt_sat > peak_r) peak_nxt = cnt_sat;
            if (cnt_sat > lim_r && pkt_i.expired != EXP_MAX) begin
              pkt_nxt.expired = pkt_i.expired + 5'd1;
            end
          end
        end
        OP_READ: begin
          if (sel_me) begin
            pkt_nxt.used = used_r;
            pkt_nxt.cnt  = cnt_r;
            pkt_nxt.peak = peak_r;
            pkt_nxt.lim  = lim_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= 1'b0;
      pkt_r.valid <= 1'b0;
    end else if (adv) begin
      used_r <= used_nxt;
      cnt_r  <= cnt_nxt;
      peak_r <= peak_nxt;
      lim_r  <= lim_nxt;
      pkt_r  <= pkt_nxt;
    end
  end

  assign pkt_o = pkt_r;

endmodule
`default_nettype wire

@@ rtl/core/multi_slot_software_watchdog_unit.sv @@
// Top level: multi-slot watchdog table built as a chain of slot cells.
//
//   channel | dir | handshake     | contents
//   in_ch   | in  | valid/ready   | opcode, slot_sel, timeout_value
//   out_ch  | out | valid/ready   | status, slot_out, expired_count, kick, slot fields
//   cfg_*   | in  | APB, pready=1 | count_step at byte address 0
//
// A command word walks the chain one cell per cycle unless the chain is held; its result
// is registered at the output when it leaves the tail, and only then is the next word taken,
// so only one word is in the chain at a time.
// A result stalled at the output freezes the chain once the next word reaches the tail.
// Synchronous reset frees every slot and sets count_step to 10; slot counters,
// peaks and timeouts are not cleared and are written by join.
`default_nettype none
module multi_slot_software_watchdog_unit
  import mswd_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  mswd_in_if.sink                in_ch,
  mswd_out_if.source             out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);

  logic [7:0] step_r;
  logic       busy_r, busy_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc, adv, load;

  pkt_t chain [SLOTS+1];
  pkt_t tail;

  logic [1:0]  status_r, status_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic [4:0]  exp_r, exp_nxt;
  logic        kick_r, kick_nxt;
  logic        used_r, used_nxt;
  logic [15:0] cnt_r, peak_r, lim_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_COUNT_STEP) ? {24'b0, step_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_COUNT_STEP) begin
      step_r <= cfg_pwdata[7:0];
    end
  end

  // inject the accepted word into the first cell
  assign in_ch.ready = !busy_r;
  assign in_acc      = in_ch.valid && !busy_r;

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = in_acc;
    chain[0].op    = op_t'(in_ch.opcode);
    chain[0].sel   = in_ch.slot_sel;
    chain[0].tmo   = in_ch.timeout_value;
  end

  assign tail = chain[SLOTS];
  // hold the chain while the finished word cannot leave
  assign adv  = !(tail.valid && out_valid_r && !out_ch.ready);
  assign load = tail.valid && adv;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    mswd_cell #(.IDX(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .step  (step_r),
      .pkt_i (chain[k]),
      .pkt_o (chain[k+1])
    );
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) busy_nxt = 1'b1;
    else if (load) busy_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  // shape the result word from the finished packet
  always_comb begin
    status_nxt = ST_OK;
    slot_nxt   = '0;
    exp_nxt    = '0;
    kick_nxt   = 1'b0;
    used_nxt   = 1'b0;
    case (tail.op)
      OP_JOIN: begin
        status_nxt = tail.found ? ST_OK : ST_FULL;
        slot_nxt   = tail.found ? tail.slot : 4'd0;
      end
      OP_SETTO, OP_LEAVE, OP_CLEAR: begin
        status_nxt = tail.hit ? ST_OK : ST_UNUSED;
        slot_nxt   = tail.sel;
      end
      OP_TICK: begin
        exp_nxt  = tail.expired;
        kick_nxt = (tail.expired == 5'd0);
      end
      OP_READ: begin
        status_nxt = tail.used ? ST_OK : ST_UNUSED;
        slot_nxt   = tail.sel;
        used_nxt   = tail.used;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      exp_r    <= exp_nxt;
      kick_r   <= kick_nxt;
      used_r   <= used_nxt;
      cnt_r    <= (tail.op == OP_READ) ? tail.cnt  : 16'd0;
      peak_r   <= (tail.op == OP_READ) ? tail.peak : 16'd0;
      lim_r    <= (tail.op == OP_READ) ? tail.lim  : 16'd0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.slot_out      = slot_r;
  assign out_ch.expired_count = exp_r;
  assign out_ch.kick          = kick_r;
  assign out_ch.slot_used     = used_r;
  assign out_ch.slot_count    = cnt_r;
  assign out_ch.slot_peak     = peak_r;
  assign out_ch.slot_timeout  = lim_r;

endmodule
`default_nettype wire

@@ rtl/core/mswd_checker.sv @@
// Port-level checker for the watchdog table, bound to the top level.
`default_nettype none
`include "multi_slot_software_watchdog_unit_defines.svh"
module mswd_checker
  import mswd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [3:0]  slot_out,
  input wire logic [4:0]  expired_count,
  input wire logic        kick
);

  // a stalled result word stays offered
  `MSWD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  // one word at a time: no accept right after an accept
  `MSWD_ASSERT_NEXT(a_one_inflight, in_valid && in_ready, !in_ready, "second word taken in flight")
  `MSWD_ASSERT_NOW(a_kick_clean, out_valid && kick, expired_count == 5'd0, "kick with expiry")
  `MSWD_ASSERT_NOW(a_full_slot, out_valid && status == ST_FULL, slot_out == 4'd0, "slot on full")

endmodule

bind multi_slot_software_watchdog_unit mswd_checker u_mswd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .slot_out      (out_ch.slot_out),
  .expired_count (out_ch.expired_count),
  .kick          (out_ch.kick)
);
`default_nettype wire
